### hdl/tnap_pkg.sv
// types and constants shared by the triangle normal arrow projection block
// no dependencies
package tnap_pkg;

    typedef enum logic [2:0] {
        CFG_ORIGIN_COL    = 3'd0,
        CFG_ORIGIN_ROW    = 3'd1,
        CFG_SHIFT_X       = 3'd2,
        CFG_SHIFT_Y       = 3'd3,
        CFG_SHIFT_Z       = 3'd4,
        CFG_PIXEL_SCALE   = 3'd5,
        CFG_DEPTH_SCALE   = 3'd6,
        CFG_NORMAL_LENGTH = 3'd7
    } t_cfg_idx;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned COORD_W    = 32;
    localparam int unsigned DIFF_W     = COORD_W + 1;
    localparam int unsigned TSUM_W     = COORD_W + 2;
    localparam int unsigned RAD_W      = 64;
    localparam int unsigned ROOT_W     = 32;
    localparam int unsigned NUM_W      = 63;

    typedef struct packed {
        logic [14:0]        origin_col;
        logic [14:0]        origin_row;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
        logic [31:0]        pixel_scale;
        logic [31:0]        depth_scale;
        logic [30:0]        normal_length;
    } t_cfg;

    typedef struct packed {
        logic signed [DIFF_W-1:0] d1x;
        logic signed [DIFF_W-1:0] d1y;
        logic signed [DIFF_W-1:0] d1z;
        logic signed [DIFF_W-1:0] d2x;
        logic signed [DIFF_W-1:0] d2y;
        logic signed [DIFF_W-1:0] d2z;
        logic signed [TSUM_W-1:0] tx;
        logic signed [TSUM_W-1:0] ty;
        logic signed [TSUM_W-1:0] tz;
    } t_tri;

    typedef struct packed {
        logic vld;
        t_tri tri_d;
    } t_fq_out;

endpackage

### hdl/tnap_front.sv
// front end: accepts a triangle, forms edge differences and vertex sum,
// and queues them for the back end; uses tnap_pkg
module tnap_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [31:0]    i_ax,
    input  logic signed [31:0]    i_ay,
    input  logic signed [31:0]    i_az,
    input  logic signed [31:0]    i_bx,
    input  logic signed [31:0]    i_by,
    input  logic signed [31:0]    i_bz,
    input  logic signed [31:0]    i_cx,
    input  logic signed [31:0]    i_cy,
    input  logic signed [31:0]    i_cz,
    output tnap_pkg::t_fq_out     o_q,
    input  logic                  i_pop
);
    import tnap_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    t_tri               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;
    logic [PTR_W:0]     n_count;
    t_tri               n_tri;
    logic               push;
    logic               pop;

    assign o_ready = (r_count != (PTR_W+1)'(DEPTH));
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_count != '0);

    always_comb begin
        n_tri.d1x = $signed({i_ax[31], i_ax}) - $signed({i_bx[31], i_bx});
        n_tri.d1y = $signed({i_ay[31], i_ay}) - $signed({i_by[31], i_by});
        n_tri.d1z = $signed({i_az[31], i_az}) - $signed({i_bz[31], i_bz});
        n_tri.d2x = $signed({i_bx[31], i_bx}) - $signed({i_cx[31], i_cx});
        n_tri.d2y = $signed({i_by[31], i_by}) - $signed({i_cy[31], i_cy});
        n_tri.d2z = $signed({i_bz[31], i_bz}) - $signed({i_cz[31], i_cz});
        n_tri.tx  = $signed({{2{i_ax[31]}}, i_ax}) + $signed({{2{i_bx[31]}}, i_bx})
                  + $signed({{2{i_cx[31]}}, i_cx});
        n_tri.ty  = $signed({{2{i_ay[31]}}, i_ay}) + $signed({{2{i_by[31]}}, i_by})
                  + $signed({{2{i_cy[31]}}, i_cy});
        n_tri.tz  = $signed({{2{i_az[31]}}, i_az}) + $signed({{2{i_bz[31]}}, i_bz})
                  + $signed({{2{i_cz[31]}}, i_cz});
    end

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= n_tri;
        end
    end

    assign o_q.vld   = (r_count != '0);
    assign o_q.tri_d = r_mem[r_rd_ptr];

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PTR_W+1)'(DEPTH))
        else $error("queue count beyond depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not grow on push");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[PTR_W-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

### hdl/tnap_isqrt.sv
// pipelined integer square root, one result bit per stage, with sideband
// no package dependency
module tnap_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [63:0]       i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [31:0]       o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int STAGES = 32;

    logic [63:0]       r_v    [1:STAGES];
    logic [63:0]       r_r    [1:STAGES];
    logic              r_vld  [1:STAGES];
    logic [SIDE_W-1:0] r_side [1:STAGES];

    genvar k;
    for (k = 0; k < STAGES; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
        logic [63:0]       v_in;
        logic [63:0]       rt_in;
        logic [63:0]       trial;
        logic              vld_in;
        logic [SIDE_W-1:0] side_in;

        if (k == 0) begin : g_first
            assign v_in    = i_rad;
            assign rt_in   = '0;
            assign vld_in  = i_vld;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k];
            assign rt_in   = r_r[k];
            assign vld_in  = r_vld[k];
            assign side_in = r_side[k];
        end

        assign trial = rt_in + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1] <= side_in;
                if (v_in >= trial) begin
                    r_v[k+1] <= v_in - trial;
                    r_r[k+1] <= (rt_in >> 1) + BIT;
                end else begin
                    r_v[k+1] <= v_in;
                    r_r[k+1] <= rt_in >> 1;
                end
            end
        end
    end

    assign o_vld  = r_vld[STAGES];
    assign o_root = r_r[STAGES][31:0];
    assign o_side = r_side[STAGES];

endmodule

### hdl/tnap_div.sv
// pipelined three-lane restoring divider with a shared divisor, one quotient
// bit per stage, with sideband; no package dependency
module tnap_div #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [2:0][62:0]  i_num,
    input  logic [31:0]       i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [2:0][31:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);
    localparam int STAGES = 32;

    logic [2:0][63:0]  r_rem  [1:STAGES];
    logic [2:0][31:0]  r_quo  [1:STAGES];
    logic [31:0]       r_den  [1:STAGES];
    logic              r_vld  [1:STAGES];
    logic [SIDE_W-1:0] r_side [1:STAGES];

    genvar k;
    for (k = 0; k < STAGES; k++) begin : g_stage
        localparam int SH = STAGES - 1 - k;
        logic [2:0][63:0]  rem_in;
        logic [2:0][63:0]  rem_nx;
        logic [2:0][31:0]  quo_in;
        logic [2:0][31:0]  quo_nx;
        logic [31:0]       den_in;
        logic [63:0]       dsh;
        logic              vld_in;
        logic [SIDE_W-1:0] side_in;

        if (k == 0) begin : g_first
            assign rem_in  = {{1'b0, i_num[2]}, {1'b0, i_num[1]}, {1'b0, i_num[0]}};
            assign quo_in  = '0;
            assign den_in  = i_den;
            assign vld_in  = i_vld;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k];
            assign quo_in  = r_quo[k];
            assign den_in  = r_den[k];
            assign vld_in  = r_vld[k];
            assign side_in = r_side[k];
        end

        always_comb begin
            dsh = 64'(den_in) << SH;
            for (int l = 0; l < 3; l++) begin
                if (rem_in[l] >= dsh) begin
                    rem_nx[l] = rem_in[l] - dsh;
                    quo_nx[l] = quo_in[l] | (32'd1 << SH);
                end else begin
                    rem_nx[l] = rem_in[l];
                    quo_nx[l] = quo_in[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= rem_nx;
                r_quo[k+1]  <= quo_nx;
                r_den[k+1]  <= den_in;
                r_side[k+1] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[STAGES];
    assign o_quo  = r_quo[STAGES];
    assign o_side = r_side[STAGES];

endmodule

### hdl/tnap_back.sv
// back end: cross product, normalization, square root, scaling division and
// oblique projection with rounding and saturation; uses tnap_pkg, tnap_isqrt,
// tnap_div
module tnap_back #(
    parameter int FRAC_BITS  = 16,
    parameter int PIXEL_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tnap_pkg::t_cfg               i_cfg,
    input  tnap_pkg::t_fq_out            i_q,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [PIXEL_BITS-1:0] o_start_col,
    output logic signed [PIXEL_BITS-1:0] o_start_row,
    output logic signed [PIXEL_BITS-1:0] o_end_col,
    output logic signed [PIXEL_BITS-1:0] o_end_row,
    output logic                         o_degenerate,
    output logic                         o_clipped
);
    import tnap_pkg::*;

    localparam int U_W    = 38;
    localparam int P_W    = 71;
    localparam int W_W    = 76;
    localparam int LO_W   = PIXEL_BITS + 1;
    localparam int MSH    = PIXEL_BITS + 3;
    localparam int MUL_W  = PIXEL_BITS + 2;
    localparam int PROD_W = LO_W + MUL_W;
    localparam int MUL_I  = (1 << MSH) / 3 + 1;
    localparam logic [MUL_W-1:0] MUL_C = MUL_W'(MUL_I);
    localparam logic signed [W_W-1:0] HALF3 = W_W'(3) << (2*FRAC_BITS - 1);
    localparam logic [W_W-1:0] TH_POS = W_W'(3) << (PIXEL_BITS - 1);
    localparam logic [W_W-1:0] TH_NEG = TH_POS + W_W'(3);
    localparam logic signed [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
    localparam logic signed [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

    typedef struct packed {
        logic [2:0][30:0]        m;
        logic [2:0]              sgn;
        logic                    degen;
        logic [2:0][TSUM_W-1:0]  t;
    } t_side_a;

    typedef struct packed {
        logic [2:0]              sgn;
        logic                    degen;
        logic [2:0][TSUM_W-1:0]  t;
    } t_side_b;

    function automatic logic [6:0] f_bitlen(input logic [65:0] v);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 66; i++) begin
            if (v[i]) begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

    logic en;

    // stage 1: partial products of the cross product
    logic                     r_vld1;
    logic signed [65:0]       r1_p [6];
    logic [2:0][TSUM_W-1:0]   r1_t;
    // stage 2: cross product sign and magnitude
    logic                     r_vld2;
    logic [2:0]               r2_sgn;
    logic [65:0]              r2_mag [3];
    logic [2:0][TSUM_W-1:0]   r2_t;
    logic signed [66:0]       cr [3];
    // stage 3: common bit length
    logic                     r_vld3;
    logic [6:0]               r3_bl;
    logic [2:0]               r3_sgn;
    logic [65:0]              r3_mag [3];
    logic [2:0][TSUM_W-1:0]   r3_t;
    // stage 4: normalized magnitudes
    logic                     r_vld4;
    logic [2:0][30:0]         r4_m;
    logic [2:0]               r4_sgn;
    logic                     r4_degen;
    logic [2:0][TSUM_W-1:0]   r4_t;
    logic [65:0]              nsh [3];
    // stage 5: squares
    logic                     r_vld5;
    logic [61:0]              r5_sq [3];
    t_side_a                  r5_side;
    // stage 6: sum of squares
    logic                     r_vld6;
    logic [RAD_W-1:0]         r6_sum;
    t_side_a                  r6_side;
    // square root
    logic                     sq_vld;
    logic [ROOT_W-1:0]        sq_root;
    t_side_a                  sq_side;
    // stage 7: numerators
    logic                     r_vld7;
    logic [2:0][NUM_W-1:0]    r7_num;
    logic [31:0]              r7_den;
    t_side_b                  r7_side;
    logic [31:0]              root_nz;
    // division
    logic                     dv_vld;
    logic [2:0][31:0]         dv_quo;
    t_side_b                  dv_side;
    // stage 8: shifted triple coordinates of start and end
    logic                     r_vld8;
    logic signed [U_W-1:0]    r8_us [3];
    logic signed [U_W-1:0]    r8_ue [3];
    logic                     r8_degen;
    logic signed [32:0]       nrm [3];
    logic signed [U_W-1:0]    shf [3];
    // stage 9: projection products, order x, y, z for start then end
    logic                     r_vld9;
    logic signed [P_W-1:0]    r9_p [6];
    logic                     r9_degen;
    // stage 10: scaled pixel values times three: start col, start row, end col, end row
    logic                     r_vld10;
    logic signed [W_W-1:0]    r10_w [4];
    logic                     r10_degen;
    logic signed [W_W-1:0]    oc3;
    logic signed [W_W-1:0]    or3;
    // stage 11: magnitude and saturation
    logic                     r_vld11;
    logic [3:0]               r11_neg;
    logic [3:0]               r11_sat;
    logic [LO_W-1:0]          r11_lo [4];
    logic                     r11_degen;
    logic [W_W-1:0]           amag [4];
    // stage 12: divide by three
    logic                     r_vld12;
    logic [3:0]               r12_neg;
    logic [3:0]               r12_sat;
    logic [PROD_W-1:0]        r12_prod [4];
    logic                     r12_degen;
    // stage 13: output register
    logic                     r_vld13;
    logic signed [PIXEL_BITS-1:0] r13_pix [4];
    logic                     r13_degen;
    logic                     r13_clip;
    logic signed [PIXEL_BITS-1:0] pix [4];
    logic [PIXEL_BITS-1:0]    quo3 [4];
    t_side_a                  s4_side;
    t_side_b                  s7_side;

    assign en    = !r_vld13 || i_ready;
    assign o_pop = en && i_q.vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1  <= 1'b0;
            r_vld2  <= 1'b0;
            r_vld3  <= 1'b0;
            r_vld4  <= 1'b0;
            r_vld5  <= 1'b0;
            r_vld6  <= 1'b0;
            r_vld7  <= 1'b0;
            r_vld8  <= 1'b0;
            r_vld9  <= 1'b0;
            r_vld10 <= 1'b0;
            r_vld11 <= 1'b0;
            r_vld12 <= 1'b0;
            r_vld13 <= 1'b0;
        end else if (en) begin
            r_vld1  <= i_q.vld;
            r_vld2  <= r_vld1;
            r_vld3  <= r_vld2;
            r_vld4  <= r_vld3;
            r_vld5  <= r_vld4;
            r_vld6  <= r_vld5;
            r_vld7  <= sq_vld;
            r_vld8  <= dv_vld;
            r_vld9  <= r_vld8;
            r_vld10 <= r_vld9;
            r_vld11 <= r_vld10;
            r_vld12 <= r_vld11;
            r_vld13 <= r_vld12;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cr[i] = 67'(r1_p[2*i]) - 67'(r1_p[2*i+1]);
        end
        for (int i = 0; i < 3; i++) begin
            if (r3_bl > 7'd31) begin
                nsh[i] = r3_mag[i] >> (r3_bl - 7'd31);
            end else begin
                nsh[i] = r3_mag[i] << (7'd31 - r3_bl);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p[0] <= $signed(i_q.tri_d.d1y) * $signed(i_q.tri_d.d2z);
            r1_p[1] <= $signed(i_q.tri_d.d1z) * $signed(i_q.tri_d.d2y);
            r1_p[2] <= $signed(i_q.tri_d.d1z) * $signed(i_q.tri_d.d2x);
            r1_p[3] <= $signed(i_q.tri_d.d1x) * $signed(i_q.tri_d.d2z);
            r1_p[4] <= $signed(i_q.tri_d.d1x) * $signed(i_q.tri_d.d2y);
            r1_p[5] <= $signed(i_q.tri_d.d1y) * $signed(i_q.tri_d.d2x);
            r1_t    <= {i_q.tri_d.tz, i_q.tri_d.ty, i_q.tri_d.tx};

            for (int i = 0; i < 3; i++) begin
                r2_sgn[i] <= cr[i][66];
                r2_mag[i] <= cr[i][66] ? 66'(-cr[i]) : cr[i][65:0];
            end
            r2_t <= r1_t;

            r3_bl  <= f_bitlen(r2_mag[0] | r2_mag[1] | r2_mag[2]);
            r3_sgn <= r2_sgn;
            r3_mag <= r2_mag;
            r3_t   <= r2_t;

            for (int i = 0; i < 3; i++) begin
                r4_m[i] <= nsh[i][30:0];
            end
            r4_sgn   <= r3_sgn;
            r4_degen <= (r3_bl == '0);
            r4_t     <= r3_t;

            for (int i = 0; i < 3; i++) begin
                r5_sq[i] <= 62'(r4_m[i]) * 62'(r4_m[i]);
            end
            r5_side <= s4_side;

            r6_sum  <= 64'(r5_sq[0]) + 64'(r5_sq[1]) + 64'(r5_sq[2]);
            r6_side <= r5_side;
        end
    end

    always_comb begin
        s4_side.m     = r4_m;
        s4_side.sgn   = r4_sgn;
        s4_side.degen = r4_degen;
        s4_side.t     = r4_t;
    end

    tnap_isqrt #(
        .SIDE_W ($bits(t_side_a))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_vld6),
        .i_rad   (r6_sum),
        .i_side  (r6_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign root_nz = (sq_root == '0) ? 32'd1 : sq_root;

    always_comb begin
        s7_side.sgn   = sq_side.sgn;
        s7_side.degen = sq_side.degen;
        s7_side.t     = sq_side.t;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r7_num[i] <= NUM_W'(sq_side.m[i]) * NUM_W'(i_cfg.normal_length)
                           + NUM_W'(root_nz >> 1);
            end
            r7_den  <= root_nz;
            r7_side <= s7_side;
        end
    end

    tnap_div #(
        .SIDE_W ($bits(t_side_b))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_vld7),
        .i_num   (r7_num),
        .i_den   (r7_den),
        .i_side  (r7_side),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    always_comb begin
        shf[0] = U_W'(i_cfg.shift_x);
        shf[1] = U_W'(i_cfg.shift_y);
        shf[2] = U_W'(i_cfg.shift_z);
        for (int i = 0; i < 3; i++) begin
            if (dv_side.degen) begin
                nrm[i] = '0;
            end else if (dv_side.sgn[i]) begin
                nrm[i] = -$signed({1'b0, dv_quo[i]});
            end else begin
                nrm[i] = $signed({1'b0, dv_quo[i]});
            end
        end
        oc3 = $signed((W_W'(i_cfg.origin_col) * W_W'(3)) << (2*FRAC_BITS));
        or3 = $signed((W_W'(i_cfg.origin_row) * W_W'(3)) << (2*FRAC_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r8_us[i] <= U_W'($signed(dv_side.t[i])) - shf[i] * U_W'(3);
                r8_ue[i] <= U_W'($signed(dv_side.t[i])) + U_W'(nrm[i]) * U_W'(3)
                          - shf[i] * U_W'(3);
            end
            r8_degen <= dv_side.degen;

            r9_p[0] <= r8_us[0] * $signed({1'b0, i_cfg.pixel_scale});
            r9_p[1] <= r8_us[1] * $signed({1'b0, i_cfg.pixel_scale});
            r9_p[2] <= r8_us[2] * $signed({1'b0, i_cfg.depth_scale});
            r9_p[3] <= r8_ue[0] * $signed({1'b0, i_cfg.pixel_scale});
            r9_p[4] <= r8_ue[1] * $signed({1'b0, i_cfg.pixel_scale});
            r9_p[5] <= r8_ue[2] * $signed({1'b0, i_cfg.depth_scale});
            r9_degen <= r8_degen;

            r10_w[0] <= oc3 + W_W'(r9_p[0]) + W_W'(r9_p[2]) + HALF3;
            r10_w[1] <= or3 - W_W'(r9_p[1]) - W_W'(r9_p[2]) + HALF3;
            r10_w[2] <= oc3 + W_W'(r9_p[3]) + W_W'(r9_p[5]) + HALF3;
            r10_w[3] <= or3 - W_W'(r9_p[4]) - W_W'(r9_p[5]) + HALF3;
            r10_degen <= r9_degen;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            amag[i] = (r10_w[i][W_W-1] ? W_W'(-r10_w[i]) : W_W'(r10_w[i]))
                      >> (2*FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r11_neg[i] <= r10_w[i][W_W-1];
                r11_sat[i] <= r10_w[i][W_W-1] ? (amag[i] >= TH_NEG) : (amag[i] >= TH_POS);
                r11_lo[i]  <= amag[i][LO_W-1:0];
            end
            r11_degen <= r10_degen;

            for (int i = 0; i < 4; i++) begin
                r12_prod[i] <= PROD_W'(r11_lo[i]) * PROD_W'(MUL_C);
            end
            r12_neg   <= r11_neg;
            r12_sat   <= r11_sat;
            r12_degen <= r11_degen;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            quo3[i] = r12_prod[i][MSH +: PIXEL_BITS];
            if (r12_sat[i]) begin
                pix[i] = r12_neg[i] ? PIX_MIN : PIX_MAX;
            end else if (r12_neg[i]) begin
                pix[i] = -$signed(quo3[i]);
            end else begin
                pix[i] = $signed(quo3[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r13_pix   <= pix;
            r13_degen <= r12_degen;
            r13_clip  <= |r12_sat;
        end
    end

    assign o_valid      = r_vld13;
    assign o_start_col  = r13_pix[0];
    assign o_start_row  = r13_pix[1];
    assign o_end_col    = r13_pix[2];
    assign o_end_row    = r13_pix[3];
    assign o_degenerate = r13_degen;
    assign o_clipped    = r13_clip;

`ifndef SYNTH
    a_degen_tip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
            (o_end_col == o_start_col) && (o_end_row == o_start_row))
        else $error("degenerate transaction with tip away from start");
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld4 && !r4_degen) |-> (r4_m[0][30] || r4_m[1][30] || r4_m[2][30]))
        else $error("normalized cross product out of range");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && r_vld12) |=> r_vld12)
        else $error("pipeline moved during stall");
`endif

endmodule

### hdl/triangle_normal_arrow_projection.sv
// top level of the triangle normal arrow projection block: configuration
// registers, front end queue and back end pipeline; uses tnap_pkg,
// tnap_front, tnap_back
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------
//  config   | in        | i_cfg_we            | i_cfg_idx, i_cfg_data
//  triangle | in        | i_valid / o_ready   | i_ax .. i_cz
//  arrow    | out       | o_valid / i_ready   | o_start_*, o_end_*, o_degenerate,
//           |           |                     | o_clipped
//
// one transaction per cycle sustained while the receiver holds i_ready high
// most of the pipeline depth lies in the 32-stage square root and the 32-stage divider
// a four-entry queue sits behind the front end; the back end pipeline
// freezes as a whole while the output register holds an untaken result
// reset is synchronous active low, clears valid bits and queue and loads config defaults
module triangle_normal_arrow_projection #(
    parameter int FRAC_BITS  = 16,
    parameter int PIXEL_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_idx,
    input  logic [31:0]                  i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [31:0]           i_ax,
    input  logic signed [31:0]           i_ay,
    input  logic signed [31:0]           i_az,
    input  logic signed [31:0]           i_bx,
    input  logic signed [31:0]           i_by,
    input  logic signed [31:0]           i_bz,
    input  logic signed [31:0]           i_cx,
    input  logic signed [31:0]           i_cy,
    input  logic signed [31:0]           i_cz,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [PIXEL_BITS-1:0] o_start_col,
    output logic signed [PIXEL_BITS-1:0] o_start_row,
    output logic signed [PIXEL_BITS-1:0] o_end_col,
    output logic signed [PIXEL_BITS-1:0] o_end_row,
    output logic                         o_degenerate,
    output logic                         o_clipped
);
    import tnap_pkg::*;

    t_cfg    r_cfg;
    t_fq_out fq;
    logic    pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_col    <= '0;
            r_cfg.origin_row    <= '0;
            r_cfg.shift_x       <= '0;
            r_cfg.shift_y       <= '0;
            r_cfg.shift_z       <= '0;
            r_cfg.pixel_scale   <= 32'd65536;
            r_cfg.depth_scale   <= '0;
            r_cfg.normal_length <= 31'd65536;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_COL:    r_cfg.origin_col    <= i_cfg_data[14:0];
                CFG_ORIGIN_ROW:    r_cfg.origin_row    <= i_cfg_data[14:0];
                CFG_SHIFT_X:       r_cfg.shift_x       <= $signed(i_cfg_data);
                CFG_SHIFT_Y:       r_cfg.shift_y       <= $signed(i_cfg_data);
                CFG_SHIFT_Z:       r_cfg.shift_z       <= $signed(i_cfg_data);
                CFG_PIXEL_SCALE:   r_cfg.pixel_scale   <= i_cfg_data;
                CFG_DEPTH_SCALE:   r_cfg.depth_scale   <= i_cfg_data;
                CFG_NORMAL_LENGTH: r_cfg.normal_length <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    tnap_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_ax    (i_ax),
        .i_ay    (i_ay),
        .i_az    (i_az),
        .i_bx    (i_bx),
        .i_by    (i_by),
        .i_bz    (i_bz),
        .i_cx    (i_cx),
        .i_cy    (i_cy),
        .i_cz    (i_cz),
        .o_q     (fq),
        .i_pop   (pop)
    );

    tnap_back #(
        .FRAC_BITS  (FRAC_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q          (fq),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_start_col  (o_start_col),
        .o_start_row  (o_start_row),
        .o_end_col    (o_end_col),
        .o_end_row    (o_end_row),
        .o_degenerate (o_degenerate),
        .o_clipped    (o_clipped)
    );

endmodule

### bench/triangle_normal_arrow_projection_tb.sv
// self-checking bench for triangle_normal_arrow_projection: random and directed triangles
// under several projection settings, expected arrows computed locally with the same integer steps as the RTL
// depends on tnap_pkg and the block's RTL
`timescale 1ns / 100ps

module triangle_normal_arrow_projection_tb;
    import tnap_pkg::*;

    localparam int FRAC = 16;
    localparam int PIX  = 16;
    localparam int LATENCY = 77;

    typedef struct packed {
        logic signed [15:0] start_col;
        logic signed [15:0] start_row;
        logic signed [15:0] end_col;
        logic signed [15:0] end_row;
        logic               degenerate;
        logic               clipped;
    } t_arrow;

    typedef logic signed [31:0] t_tri9 [9];

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [2:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_valid = 0, i_ready = 0;
    logic signed [31:0] i_ax = 0, i_ay = 0, i_az = 0, i_bx = 0, i_by = 0, i_bz = 0;
    logic signed [31:0] i_cx = 0, i_cy = 0, i_cz = 0;
    logic o_ready, o_valid, o_degenerate, o_clipped;
    logic signed [15:0] o_start_col, o_start_row, o_end_col, o_end_row;

    t_cfg   cfg;
    t_arrow arrow_q[$];
    int errors = 0, sent = 0, got = 0, degen_cnt = 0, clip_cnt = 0;
    int stall_mode = 0;

    triangle_normal_arrow_projection uut (.*);

    always #5 i_clk = ~i_clk;

    // round three times the pixel, a signed Q96.32 value, divide by 3, saturate
    function automatic logic signed [15:0] finish_pixel(logic signed [127:0] v3,
                                                       inout logic clip);
        logic signed [127:0] w;
        logic [127:0] mag, q;
        logic neg;
        w = v3 + (128'sd3 <<< (2 * FRAC - 1));
        neg = w[127];
        mag = neg ? -w : w;
        q = (mag >> (2 * FRAC)) / 3;
        if (!neg && q > 32767) begin
            clip = 1;
            return 16'sh7fff;
        end
        if (neg && q > 32768) begin
            clip = 1;
            return 16'sh8000;
        end
        return neg ? -q[15:0] : q[15:0];
    endfunction

    function automatic void project_point(logic signed [127:0] ux,
                                          logic signed [127:0] uy,
                                          logic signed [127:0] uz,
                                          output logic signed [15:0] col,
                                          output logic signed [15:0] row,
                                          inout logic clip);
        logic signed [127:0] zt, c, r, ps;
        ps = $signed({96'd0, cfg.pixel_scale});
        zt = uz * $signed({96'd0, cfg.depth_scale});
        c = ($signed({113'd0, cfg.origin_col}) * 3 <<< (2 * FRAC)) + ux * ps + zt;
        r = ($signed({113'd0, cfg.origin_row}) * 3 <<< (2 * FRAC)) - (uy * ps + zt);
        col = finish_pixel(c, clip);
        row = finish_pixel(r, clip);
    endfunction

    function automatic t_arrow predict_arrow(t_tri9 v);
        logic signed [127:0] d1[3], d2[3], ts[3], sh[3], cr[3], nrm[3];
        logic [127:0] mag[3], t;
        logic [63:0] m[3], sum, root_v, rem, q, bit_v;
        int bl, b;
        t_arrow a;
        logic clip;
        clip = 0;
        sh[0] = cfg.shift_x;
        sh[1] = cfg.shift_y;
        sh[2] = cfg.shift_z;
        for (int i = 0; i < 3; i++) begin
            d1[i] = 128'(v[i]) - 128'(v[3+i]);
            d2[i] = 128'(v[3+i]) - 128'(v[6+i]);
            ts[i] = 128'(v[i]) + 128'(v[3+i]) + 128'(v[6+i]);
            nrm[i] = 0;
        end
        cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
        cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
        cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
        bl = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = cr[i][127] ? -cr[i] : cr[i];
            b = 0;
            for (int k = 0; k < 128; k++) if (mag[i][k]) b = k + 1;
            if (b > bl) bl = b;
        end
        a.degenerate = (bl == 0);
        if (bl != 0) begin
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                t = (bl > 31) ? mag[i] >> (bl - 31) : mag[i] << (31 - bl);
                m[i] = t[63:0];
                sum += m[i] * m[i];
            end
            rem = sum;
            root_v = 0;
            bit_v = 64'd1 << 62;
            while (bit_v > rem) bit_v >>= 2;
            while (bit_v != 0) begin
                if (rem >= root_v + bit_v) begin
                    rem -= root_v + bit_v;
                    root_v = (root_v >> 1) + bit_v;
                end else begin
                    root_v >>= 1;
                end
                bit_v >>= 2;
            end
            if (root_v == 0) root_v = 1;
            for (int i = 0; i < 3; i++) begin
                q = (m[i] * 64'(cfg.normal_length) + root_v / 2) / root_v;
                nrm[i] = cr[i][127] ? -$signed({64'd0, q}) : $signed({64'd0, q});
            end
        end
        project_point(ts[0] - 3 * sh[0], ts[1] - 3 * sh[1], ts[2] - 3 * sh[2],
                      a.start_col, a.start_row, clip);
        project_point(ts[0] + 3 * nrm[0] - 3 * sh[0], ts[1] + 3 * nrm[1] - 3 * sh[1],
                      ts[2] + 3 * nrm[2] - 3 * sh[2], a.end_col, a.end_row, clip);
        a.clipped = clip;
        return a;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        case (idx)
            CFG_ORIGIN_COL:    cfg.origin_col = data[14:0];
            CFG_ORIGIN_ROW:    cfg.origin_row = data[14:0];
            CFG_SHIFT_X:       cfg.shift_x = data;
            CFG_SHIFT_Y:       cfg.shift_y = data;
            CFG_SHIFT_Z:       cfg.shift_z = data;
            CFG_PIXEL_SCALE:   cfg.pixel_scale = data;
            CFG_DEPTH_SCALE:   cfg.depth_scale = data;
            CFG_NORMAL_LENGTH: cfg.normal_length = data[30:0];
            default: ;
        endcase
    endtask

    task automatic drain_arrows();
        while (arrow_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    task automatic set_projection(logic [14:0] oc, logic [14:0] orow, logic [31:0] sx,
                                  logic [31:0] sy, logic [31:0] sz, logic [31:0] ps,
                                  logic [31:0] ds, logic [30:0] nl);
        drain_arrows();
        write_reg(CFG_ORIGIN_COL, {17'd0, oc});
        write_reg(CFG_ORIGIN_ROW, {17'd0, orow});
        write_reg(CFG_SHIFT_X, sx);
        write_reg(CFG_SHIFT_Y, sy);
        write_reg(CFG_SHIFT_Z, sz);
        write_reg(CFG_PIXEL_SCALE, ps);
        write_reg(CFG_DEPTH_SCALE, ds);
        write_reg(CFG_NORMAL_LENGTH, {1'b0, nl});
        i_cfg_we <= 0;
    endtask

    // called at a falling edge; returns at a falling edge after acceptance
    task automatic send_triangle(t_tri9 v);
        i_ax <= v[0]; i_ay <= v[1]; i_az <= v[2];
        i_bx <= v[3]; i_by <= v[4]; i_bz <= v[5];
        i_cx <= v[6]; i_cy <= v[7]; i_cz <= v[8];
        i_valid <= 1;
        do @(posedge i_clk); while (!o_ready);
        arrow_q.push_back(predict_arrow(v));
        sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2: return $signed($urandom_range(0, 2000)) - 1000;
            default: return ($urandom() & 32'h00ffffff) - 32'h00800000;
        endcase
    endfunction

    task automatic send_random(int count);
        t_tri9 v;
        int gap;
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 9; k++) v[k] = rand_coord();
            case ($urandom_range(0, 9))
                0: for (int k = 3; k < 9; k++) v[k] = v[k % 3];
                1: for (int k = 0; k < 3; k++) v[6+k] = 2 * v[3+k] - v[k];
                default: ;
            endcase
            send_triangle(v);
            if ($urandom_range(0, 15) == 0) begin
                i_valid <= 0;
                gap = $urandom_range(1, 12);
                repeat (gap) @(negedge i_clk);
            end
        end
        i_valid <= 0;
    endtask

    task automatic test_directed();
        t_tri9 v;
        for (int n = 0; n < 20; n++) begin
            for (int k = 0; k < 9; k++) begin
                case (n % 5)
                    0: v[k] = 0;
                    1: v[k] = (k % 2) ? 32'h7fffffff : 32'h80000000;
                    2: v[k] = (k == 0 || k == 4 || k == 8) ? 32'h00010000 : 0;
                    3: v[k] = k * 32'h00010000;
                    default: v[k] = $urandom();
                endcase
            end
            if (n == 7) for (int k = 0; k < 9; k++) v[k] = 32'hffffffff;
            send_triangle(v);
        end
        i_valid <= 0;
        @(negedge i_clk);
    endtask

    task automatic test_reset_settings();
        test_directed();
        send_random(300);
    endtask

    task automatic test_typical_view();
        set_projection(15'd100, 15'd400, -32'sd5 <<< 16, -32'sd5 <<< 16, 0,
                       32'd20 <<< 16, 32'd8 <<< 16, 31'd2 <<< 16);
        send_random(500);
    endtask

    task automatic test_extreme_view();
        set_projection(15'h7fff, 15'h7fff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                       32'hffffffff, 32'hffffffff, 31'h7fffffff);
        test_directed();
        send_random(300);
    endtask

    task automatic test_zero_scales();
        set_projection(15'd0, 15'd0, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                       32'd0, 32'd0, 31'd0);
        send_random(200);
    endtask

    task automatic test_random_views();
        for (int p = 0; p < 4; p++) begin
            set_projection(15'($urandom()), 15'($urandom()), $urandom(), $urandom(),
                           $urandom(),
                           $urandom() >> $urandom_range(0, 31),
                           $urandom() >> $urandom_range(0, 31), 31'($urandom()));
            send_random(200);
        end
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        if ($urandom_range(0, 499) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_ready <= 1;
            1: i_ready <= $urandom_range(0, 3) != 0;
            2: i_ready <= $urandom_range(0, 1);
            default: i_ready <= $urandom_range(0, 7) == 0;
        endcase
    end

    always @(posedge i_clk) begin
        t_arrow exp_a, act;
        if (i_rst_n && o_valid && i_ready) begin
            act = '{o_start_col, o_start_row, o_end_col, o_end_row, o_degenerate, o_clipped};
            if (arrow_q.size() == 0) begin
                $display("%0t: unexpected transaction, actual %h", $time, act);
                errors++;
            end else begin
                exp_a = arrow_q.pop_front();
                got++;
                degen_cnt += exp_a.degenerate;
                clip_cnt += exp_a.clipped;
                if (exp_a.start_col !== act.start_col)
                    $display("%0t: start_col expected %0d actual %0d", $time,
                             exp_a.start_col, act.start_col);
                if (exp_a.start_row !== act.start_row)
                    $display("%0t: start_row expected %0d actual %0d", $time,
                             exp_a.start_row, act.start_row);
                if (exp_a.end_col !== act.end_col)
                    $display("%0t: end_col expected %0d actual %0d", $time,
                             exp_a.end_col, act.end_col);
                if (exp_a.end_row !== act.end_row)
                    $display("%0t: end_row expected %0d actual %0d", $time,
                             exp_a.end_row, act.end_row);
                if (exp_a.degenerate !== act.degenerate)
                    $display("%0t: degenerate expected %0b actual %0b", $time,
                             exp_a.degenerate, act.degenerate);
                if (exp_a.clipped !== act.clipped)
                    $display("%0t: clipped expected %0b actual %0b", $time,
                             exp_a.clipped, act.clipped);
                if (exp_a !== act) errors++;
            end
        end
    end

    initial begin
        cfg = '{origin_col: 0, origin_row: 0, shift_x: 0, shift_y: 0, shift_z: 0,
                pixel_scale: 32'd65536, depth_scale: 0, normal_length: 31'd65536};
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        test_reset_settings();
        test_typical_view();
        test_extreme_view();
        test_zero_scales();
        test_random_views();
        drain_arrows();
        errors += arrow_q.size();
        $display("covered %0d triangles over eight projection settings", sent);
        $display("%0d arrows checked, %0d degenerate, %0d clipped", got, degen_cnt, clip_cnt);
        if (errors == 0)
            $display("triangle_normal_arrow_projection regression: pass");
        else
            $display("triangle_normal_arrow_projection regression: fail");
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("triangle_normal_arrow_projection regression: fail");
        $finish;
    end
endmodule
